### sv/smcfr_pkg.sv
package smcfr_pkg;

	localparam int unsigned FRAME_LEN = 11;
	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
	localparam int unsigned PAYLOAD_DEPTH = 8;
	localparam int unsigned DUTY_COUNT = 4;

	localparam logic [7:0] RESTART_BYTE = 8'hFF;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [15:0] TOP_RESET = 16'd19999;
	localparam logic [15:0] SERVO_RESET = 16'd1499;
	localparam logic [16:0] SERVO_OFFSET = 17'd1023;
	// 20460 = 4 * 5115; quotient by 5115 as multiply by ceil(2^44 / 5115)
	localparam int unsigned PROD_W = 33;
	localparam int unsigned RECIP_SHIFT = 44;
	localparam logic [31:0] SERVO_RECIP = 32'd3439332561;
	localparam int unsigned QUOT_W = 63 - RECIP_SHIFT;

	typedef logic [DUTY_COUNT-1:0][7:0] duty_vec_t;

	typedef struct packed {
		logic valid;
		logic ok;
		duty_vec_t duty;
		logic [15:0] word_vert;
		logic [15:0] word_horiz;
	} frame_info_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### sv/smcfr_frame.sv
module smcfr_frame
	import smcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	output logic        at_last,
	output frame_info_t info_s1
);

	logic [POS_W-1:0] pos_q;
	logic [15:0] crc_q;
	logic [7:0] payload_q [PAYLOAD_DEPTH];
	logic restart;
	logic [15:0] crc_nx;
	logic [2:0] wr_idx;
	logic done_s1;
	logic ok_s1;
	duty_vec_t duty_s1;
	logic [15:0] vert_s1, horiz_s1;

	assign restart = (pos_q != '0) && (rx_byte == RESTART_BYTE);
	assign crc_nx = crc_feed(restart ? CRC_INIT : crc_q, rx_byte);
	assign at_last = (pos_q == POS_LAST);
	assign wr_idx = 3'(pos_q - POS_W'(1));
	assign info_s1 = '{valid: done_s1, ok: ok_s1, duty: duty_s1,
		word_vert: vert_s1, word_horiz: horiz_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= 1'b0;
			if (accept) begin
				if (restart && !at_last) begin
					pos_q <= POS_W'(1);
					crc_q <= crc_nx;
				end else if (restart) begin
					// restart byte in the last slot also starts a new frame
					pos_q <= POS_W'(1);
					crc_q <= crc_nx;
				end else if (at_last) begin
					pos_q <= '0;
					crc_q <= CRC_INIT;
					done_s1 <= 1'b1;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					crc_q <= crc_nx;
				end
			end
		end
	end

	// payload and frame snapshot carry no reset
	always_ff @(posedge clk) begin
		if (accept && !restart && (pos_q != '0) && (pos_q <= POS_W'(PAYLOAD_DEPTH))) begin
			payload_q[wr_idx] <= rx_byte;
		end
		if (accept && !restart && at_last) begin
			ok_s1 <= (crc_nx == 16'h0000);
			for (int i = 0; i < DUTY_COUNT; i++) begin
				duty_s1[i] <= payload_q[i];
			end
			vert_s1 <= {payload_q[4], payload_q[5]};
			horiz_s1 <= {payload_q[6], payload_q[7]};
		end
	end

	a_restart_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> (pos_q == POS_W'(1)))
		else $error("restart byte did not return to byte 1");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		info_s1.valid |=> !info_s1.valid)
		else $error("frame completion lasted more than one cycle");

endmodule

### sv/smcfr_scale.sv
module smcfr_scale
	import smcfr_pkg::*;
(
	input  logic        clk,
	input  logic [15:0] period_top,
	input  logic [15:0] word,
	output logic [15:0] compare_s3
);

	logic [PROD_W-1:0] prod_s2;
	logic [62:0] recip_prod;
	logic [QUOT_W-1:0] quot;

	assign recip_prod = 63'(prod_s2[PROD_W-1:2]) * 63'(SERVO_RECIP);
	assign quot = recip_prod[62:RECIP_SHIFT];

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(period_top) * PROD_W'(SERVO_OFFSET + 17'(word));
		compare_s3 <= (quot > QUOT_W'(16'hFFFF)) ? 16'hFFFF : quot[15:0];
	end

endmodule

### sv/smcfr_apply.sv
module smcfr_apply
	import smcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  frame_info_t info_s1,
	input  logic [15:0] vert_s3,
	input  logic [15:0] horiz_s3,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [71:0] out_data,
	output logic        busy
);

	logic valid_s2, valid_s3;
	logic ok_s2, ok_s3;
	duty_vec_t duty_s2, duty_s3;
	duty_vec_t duty_q;
	logic [15:0] vert_q, horiz_q;
	logic ok_q;
	logic out_valid_q;

	assign busy = info_s1.valid | valid_s2 | valid_s3 | out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = {7'b0, horiz_q, vert_q, duty_q[3], duty_q[2], duty_q[1], duty_q[0], ok_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
			duty_q <= '0;
			vert_q <= SERVO_RESET;
			horiz_q <= SERVO_RESET;
			ok_q <= 1'b0;
		end else begin
			valid_s2 <= info_s1.valid;
			valid_s3 <= valid_s2;
			if (valid_s3) begin
				out_valid_q <= 1'b1;
				ok_q <= ok_s3;
				if (ok_s3) begin
					duty_q <= duty_s3;
					vert_q <= vert_s3;
					horiz_q <= horiz_s3;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s2 <= info_s1.ok;
		duty_s2 <= info_s1.duty;
		ok_s3 <= ok_s2;
		duty_s3 <= duty_s2;
	end

	a_bad_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !ok_s3) |=> ($stable(duty_q) && $stable(vert_q) && $stable(horiz_q)))
		else $error("bad frame changed applied values");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({info_s1.valid, valid_s2, valid_s3}))
		else $error("two frames in the scaling pipeline");

endmodule

### sv/servo_motor_command_frame_receiver_unit.sv
// Servo/motor command frame receiver.
// s_axis carries received serial bytes, one per transaction, in tdata[7:0].
// Bytes build 11-byte frames; 0xFF after the first byte restarts a frame.
// A CRC-16 (reflected 0xA001, init 0xFFFF) over the whole frame must leave 0.
// m_axis gives one transaction per completed frame: the ok flag and the
// motor duties and servo compares now applied (a bad frame keeps old values).
// cfg_we/cfg_wdata write the servo period top; write only while idle.
// Throughput: one byte per cycle while s_axis_tready is high. A frame's result
// reaches m_axis through these registers: the frame register (loaded with its last
// byte), then servo product, reciprocal multiply for the divide, output register.
// A result waiting on m_axis does not stop the byte stream; only the last
// byte of the following frame is held off (tready low) until that result
// has been taken, since the output register holds one frame at a time.
// Reset: no frame in progress, duties 0, servo compares 1499, period top 19999.
module servo_motor_command_frame_receiver_unit
	import smcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // frame_ok, fwd_left, fwd_right, back_left,
	                                    // back_right, servo_vertical, servo_horizontal
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] period_top_q;
	logic accept;
	logic at_last;
	logic busy;
	frame_info_t info_s1;
	logic [15:0] vert_s3, horiz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q <= TOP_RESET;
		end else if (cfg_we) begin
			period_top_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = !(at_last && busy);
	assign accept = s_axis_tvalid && s_axis_tready;

	smcfr_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (s_axis_tdata),
		.at_last (at_last),
		.info_s1 (info_s1)
	);

	smcfr_scale u_scale_vert (
		.clk        (clk),
		.period_top (period_top_q),
		.word       (info_s1.word_vert),
		.compare_s3 (vert_s3)
	);

	smcfr_scale u_scale_horiz (
		.clk        (clk),
		.period_top (period_top_q),
		.word       (info_s1.word_horiz),
		.compare_s3 (horiz_s3)
	);

	smcfr_apply u_apply (
		.clk       (clk),
		.arst_n    (arst_n),
		.info_s1   (info_s1),
		.vert_s3   (vert_s3),
		.horiz_s3  (horiz_s3),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.busy      (busy)
	);

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		info_s1.valid |-> !m_axis_tvalid)
		else $error("new frame completed while a result was still waiting");

endmodule
